// ===== rtl/core/ple_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared widths, command and status codes, and the control bundle that the
// top level broadcasts to every cell of the list.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CAPACITY_MAX = 64;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int CNT_OUT_W = 5;

  // Wide enough for any index or count up to the largest supported capacity.
  localparam int LIDX_W = $clog2(CAPACITY_MAX + 1);

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT_AFTER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_BACK     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DELETE_AT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SEARCH       = 3'd6;
  localparam logic [CMD_W-1:0] CMD_READ_OUT     = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // Cell operations.
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_ROTATE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [LIDX_W-1:0] idx;
    logic [LIDX_W-1:0] occ;
    logic [DATA_W-1:0] load_data;
    logic [DATA_W-1:0] key;
    logic              capture;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/positional_list_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   One command item enters on the input channel (in_valid / in_stall) with
//   its command, value and position. Results leave on the output channel
//   (out_valid / out_stall), one item per result; the final result of every
//   command carries last = 1.
//   Every command except a non-empty read out has an accept step, in which
//   each cell compares its element against the value, and an execute step,
//   in which all cells shift or load at once and the result is written to
//   the output register. A non-empty read out emits its elements one at a
//   time: the head cell is emitted and the occupied cells rotate by one
//   place, so once all N elements are out the list is back in order.
//   The input side is stalled from the accept until the command's last
//   result has been written to the output register.
//   When the receiver stalls, the output register holds its item and the
//   engine waits with its edit; nothing is lost or repeated.
//   Reset empties the list and clears both channels' control state. The
//   element storage itself is not cleared; only occupied cells are read.
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ple_pkg::CMD_W-1:0]           command,
  input  logic signed [ple_pkg::DATA_W-1:0]   value,
  input  logic [ple_pkg::POS_W-1:0]           position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ple_pkg::STATUS_W-1:0]        status,
  output logic signed [ple_pkg::DATA_W-1:0]   item_value,
  output logic [ple_pkg::CNT_OUT_W-1:0]       found_at,
  output logic [ple_pkg::CNT_OUT_W-1:0]       entries,
  output logic                                last
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]        state;
  logic [CW-1:0]     occ;
  logic [CW-1:0]     rd_cnt;
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] val_r;
  logic [POS_W-1:0]  pos_r;

  logic accept;
  logic out_free;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] left_in   [CAPACITY];
  logic [DATA_W-1:0] right_in  [CAPACITY];
  logic [CAPACITY-1:0] hits;
  cell_ctrl_t cell_ctrl;

  // Execute-cycle decode.
  logic [STATUS_W-1:0]  r_status;
  logic [CNT_OUT_W-1:0] r_found;
  logic [OP_W-1:0]      r_op;
  logic [CW-1:0]        r_idx;
  logic [CW-1:0]        occ_next;
  logic                 r_to_read;
  logic                 hit_any;
  logic [CW-1:0]        hit_first;
  logic                 is_full;
  logic                 is_empty;
  logic                 pos_bad;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // The row of cells. Each cell sees its two neighbors; the ends see a
  // constant on the left and their own element on the right.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_left_end
      assign left_in[g] = '0;
    end else begin : g_left
      assign left_in[g] = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_right_end
      assign right_in[g] = cell_data[g];
    end else begin : g_right
      assign right_in[g] = cell_data[g+1];
    end

    ple_cell #(
      .INDEX(g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .left_data  (left_in[g]),
      .right_data (right_in[g]),
      .data       (cell_data[g]),
      .hit        (hits[g])
    );
  end

  // First matching cell, from the compares captured at the accept edge.
  always_comb begin
    hit_any   = 1'b0;
    hit_first = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit_any   = 1'b1;
        hit_first = CW'(i);
      end
    end
  end

  assign is_full  = (occ == CW'(CAPACITY));
  assign is_empty = (occ == '0);
  assign pos_bad  = ({1'b0, pos_r} >= (POS_W + 1)'(occ));

  always_comb begin
    r_status  = ST_OK;
    r_found   = '0;
    r_op      = OP_HOLD;
    r_idx     = '0;
    occ_next  = occ;
    r_to_read = 1'b0;
    unique case (cmd_r) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AFTER: begin
        if (is_full) begin
          r_status = ST_FULL;
        end else if (cmd_r == CMD_PUSH_FRONT) begin
          r_op     = OP_INSERT;
          r_idx    = '0;
          occ_next = occ + 1'b1;
        end else if (cmd_r == CMD_PUSH_BACK) begin
          r_op     = OP_INSERT;
          r_idx    = occ;
          occ_next = occ + 1'b1;
        end else if (is_empty) begin
          r_status = ST_EMPTY;
        end else if (pos_bad) begin
          r_status = ST_BADPOS;
        end else begin
          r_op     = OP_INSERT;
          r_idx    = CW'(pos_r) + 1'b1;
          occ_next = occ + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE_AT: begin
        if (is_empty) begin
          r_status = ST_EMPTY;
        end else if (cmd_r == CMD_POP_FRONT) begin
          r_op     = OP_REMOVE;
          r_idx    = '0;
          occ_next = occ - 1'b1;
        end else if (cmd_r == CMD_POP_BACK) begin
          r_op     = OP_REMOVE;
          r_idx    = occ - 1'b1;
          occ_next = occ - 1'b1;
        end else if (pos_bad) begin
          r_status = ST_BADPOS;
        end else begin
          r_op     = OP_REMOVE;
          r_idx    = CW'(pos_r);
          occ_next = occ - 1'b1;
        end
      end
      CMD_SEARCH: begin
        if (is_empty) begin
          r_status = ST_EMPTY;
        end else if (hit_any) begin
          r_found = CNT_OUT_W'(hit_first + 1'b1);
        end else begin
          r_status = ST_NOTFOUND;
        end
      end
      CMD_READ_OUT: begin
        if (is_empty) begin
          r_status = ST_EMPTY;
        end else begin
          r_to_read = 1'b1;
        end
      end
      default: begin
        r_status = ST_OK;
      end
    endcase
  end

  // Broadcast to the cells. The search key follows the input port so the
  // compares are captured on the accept edge itself.
  always_comb begin
    cell_ctrl.op        = OP_HOLD;
    cell_ctrl.idx       = '0;
    cell_ctrl.occ       = LIDX_W'(occ);
    cell_ctrl.load_data = val_r;
    cell_ctrl.key       = value;
    cell_ctrl.capture   = accept;
    if (state == S_RUN && out_free) begin
      cell_ctrl.op  = r_op;
      cell_ctrl.idx = LIDX_W'(r_idx);
    end else if (state == S_READ && out_free) begin
      cell_ctrl.op        = OP_ROTATE;
      cell_ctrl.idx       = LIDX_W'(occ - 1'b1);
      cell_ctrl.load_data = cell_data[0];
    end
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      occ    <= '0;
      rd_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (out_free) begin
            occ    <= occ_next;
            rd_cnt <= '0;
            state  <= r_to_read ? S_READ : S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            rd_cnt <= rd_cnt + 1'b1;
            if (rd_cnt == occ - 1'b1) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= command;
      val_r <= value;
      pos_r <= position;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == S_RUN && !r_to_read) || (state == S_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == S_RUN) begin
        status     <= r_status;
        item_value <= '0;
        found_at   <= r_found;
        entries    <= CNT_OUT_W'(occ_next);
        last       <= 1'b1;
      end else if (state == S_READ) begin
        status     <= ST_OK;
        item_value <= cell_data[0];
        found_at   <= '0;
        entries    <= CNT_OUT_W'(occ);
        last       <= (rd_cnt == occ - 1'b1);
      end
    end
  end

  // Occupancy never passes the capacity.
  a_occ_bound : assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  // Each command adds or removes at most one element.
  a_occ_step : assert property (@(posedge clk) disable iff (rst)
    (occ == $past(occ)) || (occ == $past(occ) + 1'b1) || (occ + 1'b1 == $past(occ)))
    else $error("occupancy jumped by more than one");

  // A full report only comes from a list that is full.
  a_full_status : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (occ == CW'(CAPACITY)))
    else $error("full reported on a list with room");

  // A search position is only reported together with a success status.
  a_found_ok : assert property (@(posedge clk) disable iff (rst)
    (out_valid && found_at != '0) |-> (status == ST_OK && last))
    else $error("match position on a failed result");

endmodule

// ===== rtl/core/ple_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list element, shifts toward either neighbor on edits and
// captures a compare against the search key.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  ple_pkg::cell_ctrl_t         ctrl,
  input  logic [ple_pkg::DATA_W-1:0]  left_data,
  input  logic [ple_pkg::DATA_W-1:0]  right_data,
  output logic [ple_pkg::DATA_W-1:0]  data,
  output logic                        hit
);
  import ple_pkg::*;

  logic [LIDX_W-1:0] my_idx;
  logic [DATA_W-1:0] data_next;

  assign my_idx = LIDX_W'(INDEX);

  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      OP_HOLD: begin
        data_next = data;
      end
      OP_INSERT: begin
        if (my_idx > ctrl.idx) begin
          data_next = left_data;
        end else if (my_idx == ctrl.idx) begin
          data_next = ctrl.load_data;
        end
      end
      OP_REMOVE: begin
        if (my_idx >= ctrl.idx) begin
          data_next = right_data;
        end
      end
      OP_ROTATE: begin
        // Occupied region moves one place toward the head; the old head
        // wraps around into the last occupied cell.
        if (my_idx < ctrl.idx) begin
          data_next = right_data;
        end else if (my_idx == ctrl.idx) begin
          data_next = ctrl.load_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (ctrl.capture) begin
      hit <= (data == ctrl.key) && (my_idx < ctrl.occ);
    end
  end

endmodule
